>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> hdl/md5_pkg.sv
// Package with MD5 constants, types and round helper functions.
package md5_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hEFCDAB89;
   localparam logic [31:0] INIT_C = 32'h98BADCFE;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_OFFSET = 6'd56;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUNDS,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } ctrl_state_type;

   // Byte source selection for a store write.
   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_PAD,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   typedef struct packed {
      logic         wr_en;
      byte_src_type wr_src;
      logic [5:0]   wr_addr;
      logic [7:0]   wr_data;
      logic         count_byte;
      logic         round_start;
      logic         round_step;
      logic         fold;
      logic         reinit;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
   } dp_sts_type;

   function automatic logic [31:0] round_const(input logic [5:0] j);
      logic [31:0] t;
      begin
         unique case (j)
            6'd0: t = 32'hd76aa478;  6'd1: t = 32'he8c7b756;
            6'd2: t = 32'h242070db;  6'd3: t = 32'hc1bdceee;
            6'd4: t = 32'hf57c0faf;  6'd5: t = 32'h4787c62a;
            6'd6: t = 32'ha8304613;  6'd7: t = 32'hfd469501;
            6'd8: t = 32'h698098d8;  6'd9: t = 32'h8b44f7af;
            6'd10: t = 32'hffff5bb1; 6'd11: t = 32'h895cd7be;
            6'd12: t = 32'h6b901122; 6'd13: t = 32'hfd987193;
            6'd14: t = 32'ha679438e; 6'd15: t = 32'h49b40821;
            6'd16: t = 32'hf61e2562; 6'd17: t = 32'hc040b340;
            6'd18: t = 32'h265e5a51; 6'd19: t = 32'he9b6c7aa;
            6'd20: t = 32'hd62f105d; 6'd21: t = 32'h02441453;
            6'd22: t = 32'hd8a1e681; 6'd23: t = 32'he7d3fbc8;
            6'd24: t = 32'h21e1cde6; 6'd25: t = 32'hc33707d6;
            6'd26: t = 32'hf4d50d87; 6'd27: t = 32'h455a14ed;
            6'd28: t = 32'ha9e3e905; 6'd29: t = 32'hfcefa3f8;
            6'd30: t = 32'h676f02d9; 6'd31: t = 32'h8d2a4c8a;
            6'd32: t = 32'hfffa3942; 6'd33: t = 32'h8771f681;
            6'd34: t = 32'h6d9d6122; 6'd35: t = 32'hfde5380c;
            6'd36: t = 32'ha4beea44; 6'd37: t = 32'h4bdecfa9;
            6'd38: t = 32'hf6bb4b60; 6'd39: t = 32'hbebfbc70;
            6'd40: t = 32'h289b7ec6; 6'd41: t = 32'heaa127fa;
            6'd42: t = 32'hd4ef3085; 6'd43: t = 32'h04881d05;
            6'd44: t = 32'hd9d4d039; 6'd45: t = 32'he6db99e5;
            6'd46: t = 32'h1fa27cf8; 6'd47: t = 32'hc4ac5665;
            6'd48: t = 32'hf4292244; 6'd49: t = 32'h432aff97;
            6'd50: t = 32'hab9423a7; 6'd51: t = 32'hfc93a039;
            6'd52: t = 32'h655b59c3; 6'd53: t = 32'h8f0ccc92;
            6'd54: t = 32'hffeff47d; 6'd55: t = 32'h85845dd1;
            6'd56: t = 32'h6fa87e4f; 6'd57: t = 32'hfe2ce6e0;
            6'd58: t = 32'ha3014314; 6'd59: t = 32'h4e0811a1;
            6'd60: t = 32'hf7537e82; 6'd61: t = 32'hbd3af235;
            6'd62: t = 32'h2ad7d2bb; 6'd63: t = 32'heb86d391;
            default: t = 32'h0;
         endcase
         return t;
      end
   endfunction

   function automatic logic [4:0] round_shift(input logic [5:0] j);
      logic [4:0] s;
      begin
         unique case ({j[5:4], j[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
         endcase
         return s;
      end
   endfunction

   // Message word index used by a round.
   function automatic logic [3:0] word_sel(input logic [5:0] j);
      logic [3:0] g;
      begin
         unique case (j[5:4])
            2'd0: g = j[3:0];
            2'd1: g = 4'(({2'b00, j[3:0]} * 6'd5) + 6'd1);
            2'd2: g = 4'(({2'b00, j[3:0]} * 6'd3) + 6'd5);
            2'd3: g = 4'({2'b00, j[3:0]} * 6'd7);
            default: g = 4'd0;
         endcase
         return g;
      end
   endfunction

endpackage

>>> hdl/md5_message_digest.sv
// Top level of the MD5 message digest block.
//
//  channel | direction | fields                                   | handshake
//  req_    | in        | data_byte, byte_present, end_of_message  | valid/ready
//  rsp_    | out       | word_index, digest_word, last_word       | valid/ready
//
// A request carrying a byte is written straight into the block store; the 64th byte
// of a block starts the round sequence of the single shared round unit.
// An end request writes the padding one byte a cycle (plus a second block when fewer
// than nine bytes remain), runs the rounds, and then offers the four digest words,
// which stall freely on rsp_ready.
// Synchronous reset loads the initial chaining words and an empty count.
module md5_message_digest import md5_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_word_index,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_last_word
);

`include "assert_macros.svh"

   dp_cmd_type  cmd;
   dp_sts_type  sts;
   logic [31:0] wa, wb, wc, wd;

   md5_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data_byte, .req_byte_present,
      .req_end_of_message, .rsp_valid, .rsp_ready, .rsp_word_index,
      .rsp_last_word, .cmd, .sts
   );

   md5_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .word_a(wa), .word_b(wb), .word_c(wc), .word_d(wd)
   );

   // The digest words are presented in order A, B, C, D.
   always_comb begin
      unique case (rsp_word_index)
         2'd0: rsp_digest_word = wa;
         2'd1: rsp_digest_word = wb;
         2'd2: rsp_digest_word = wc;
         2'd3: rsp_digest_word = wd;
         default: rsp_digest_word = wa;
      endcase
   end

   // Requests and results are never offered together.
   `ASSERT_IMPL(a_excl, clock, reset, rsp_valid, !req_ready)
   // The last word flag follows the fourth index.
   `ASSERT_IMPL(a_last, clock, reset, rsp_valid && rsp_last_word, rsp_word_index == 2'd3)
   // After the last word is taken the block takes requests again.
   `ASSERT_NEXT(a_done, clock, reset, rsp_valid && rsp_ready && rsp_last_word, req_ready)

endmodule

>>> hdl/md5_datapath.sv
// MD5 datapath: block store, chaining words, bit count and round unit.
module md5_datapath import md5_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_sts_type  sts,
   output logic [31:0] word_a,
   output logic [31:0] word_b,
   output logic [31:0] word_c,
   output logic [31:0] word_d
);

   // Store held as 16 little-endian words so a round reads one word.
   logic [31:0] store_mem [16];
   logic [31:0] h_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff;
   logic [5:0]  rnd_ff;
   logic [31:0] m_word;
   logic [7:0]  wbyte;
   logic [31:0] f_val, sum, rot, t_new;
   logic [4:0]  sh;

   always_comb begin
      unique case (cmd.wr_src)
         SRC_DATA: wbyte = cmd.wr_data;
         SRC_PAD:  wbyte = PAD_BYTE;
         SRC_ZERO: wbyte = 8'h00;
         SRC_LEN:  wbyte = bits_ff[{cmd.wr_addr[2:0], 3'b000} +: 8];
         default:  wbyte = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en)
         store_mem[cmd.wr_addr[5:2]][{cmd.wr_addr[1:0], 3'b000} +: 8] <= wbyte;
   end

   assign m_word = store_mem[word_sel(rnd_ff)];

   always_comb begin
      unique case (rnd_ff[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         2'd3: f_val = c_ff ^ (b_ff | ~d_ff);
         default: f_val = '0;
      endcase
      sh = round_shift(rnd_ff);
      sum = f_val + a_ff + round_const(rnd_ff) + m_word;
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
      t_new = b_ff + rot;
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.count_byte)
         fill_in = fill_ff + 6'd1;
      if (cmd.reinit)
         fill_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bits_ff <= '0;
         h_ff[0] <= INIT_A; h_ff[1] <= INIT_B; h_ff[2] <= INIT_C; h_ff[3] <= INIT_D;
         rnd_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         if (cmd.count_byte)
            bits_ff <= bits_ff + 64'd8;
         if (cmd.reinit) begin
            bits_ff <= '0;
            h_ff[0] <= INIT_A; h_ff[1] <= INIT_B;
            h_ff[2] <= INIT_C; h_ff[3] <= INIT_D;
         end else if (cmd.fold) begin
            // Folding happens with the last round, so the words after that round are added.
            h_ff[0] <= h_ff[0] + d_ff; h_ff[1] <= h_ff[1] + t_new;
            h_ff[2] <= h_ff[2] + b_ff; h_ff[3] <= h_ff[3] + c_ff;
         end
         if (cmd.round_start)
            rnd_ff <= '0;
         else if (cmd.round_step)
            rnd_ff <= rnd_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.round_start) begin
         a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2]; d_ff <= h_ff[3];
      end else if (cmd.round_step) begin
         a_ff <= d_ff; d_ff <= c_ff; c_ff <= b_ff; b_ff <= t_new;
      end
   end

   assign sts.fill = fill_ff;
   assign sts.round_last = (rnd_ff == 6'd63);
   assign word_a = h_ff[0];
   assign word_b = h_ff[1];
   assign word_c = h_ff[2];
   assign word_d = h_ff[3];

endmodule

>>> hdl/md5_control.sv
// MD5 controller: request intake, padding sequence, rounds and digest output.
module md5_control import md5_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word,
   output dp_cmd_type  cmd,
   input  dp_sts_type  sts
);

   ctrl_state_type state_ff, state_in;
   logic       end_ff, end_in;     // message end pending after the current block
   logic       final_ff, final_in; // current compression is the final one
   logic       cont_ff, cont_in;   // padding continues into a second block
   logic [5:0] ptr_ff, ptr_in;     // padding write pointer
   logic [1:0] idx_ff, idx_in;
   logic       hs;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         end_ff   <= 1'b0;
         final_ff <= 1'b0;
         cont_ff  <= 1'b0;
         ptr_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
         final_ff <= final_in;
         cont_ff  <= cont_in;
         ptr_ff   <= ptr_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign hs = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_word_index = idx_ff;
   assign rsp_last_word = (idx_ff == 2'd3);

   always_comb begin
      state_in = state_ff;
      end_in   = end_ff;
      final_in = final_ff;
      cont_in  = cont_ff;
      ptr_in   = ptr_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.wr_src  = SRC_DATA;
      cmd.wr_addr = sts.fill;
      cmd.wr_data = req_data_byte;
      unique case (state_ff)
         ST_IDLE: begin
            if (hs) begin
               end_in   = req_end_of_message;
               final_in = 1'b0;
               if (req_byte_present) begin
                  cmd.wr_en = 1'b1;
                  cmd.count_byte = 1'b1;
                  if (sts.fill == 6'd63) begin
                     state_in = ST_ROUNDS;
                     cmd.round_start = 1'b1;
                  end else if (req_end_of_message) begin
                     state_in = ST_PAD;
                     ptr_in = sts.fill + 6'd1;
                  end
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
                  ptr_in = sts.fill;
               end
            end
         end
         ST_ROUNDS: begin
            cmd.round_step = 1'b1;
            if (sts.round_last) begin
               cmd.fold = 1'b1;
               if (final_ff) begin
                  state_in = ST_OUT;
                  idx_in = '0;
               end else if (end_ff || cont_ff) begin
                  // A pending end still starts with 0x80; a continued pad starts with zeros.
                  state_in = ST_PAD;
                  ptr_in = '0;
                  cont_in = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            // 0x80 first on a pending end, then zeros to the length field or block end.
            cmd.wr_en = 1'b1;
            cmd.wr_addr = ptr_ff;
            cmd.wr_src = end_ff ? SRC_PAD : SRC_ZERO;
            end_in = 1'b0;
            ptr_in = ptr_ff + 6'd1;
            if (ptr_ff == 6'd63) begin
               state_in = ST_ROUNDS;
               cmd.round_start = 1'b1;
               final_in = 1'b0;
               end_in = 1'b0;
               cont_in = 1'b1;
            end else if (ptr_ff == LEN_OFFSET - 6'd1) begin
               state_in = ST_LEN;
            end
            if (end_ff && ptr_ff > LEN_OFFSET - 6'd1 && ptr_ff != 6'd63) begin
               state_in = ST_PAD;
            end else if (end_ff && ptr_ff == 6'd63) begin
               state_in = ST_ROUNDS;
            end
         end
         ST_LEN: begin
            cmd.wr_en = 1'b1;
            cmd.wr_addr = ptr_ff;
            cmd.wr_src = SRC_LEN;
            ptr_in = ptr_ff + 6'd1;
            if (ptr_ff == 6'd63) begin
               state_in = ST_ROUNDS;
               cmd.round_start = 1'b1;
               final_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_in = ST_IDLE;
                  cmd.reinit = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
